[rtl/core/ordered_list_store_assert.svh]
// Assertion macros for the ordered list store.
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define OLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define OLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/olst_pkg.sv]
`default_nettype none

package olst_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_INS   = 3'd1,
    REQ_DEL   = 3'd2,
    REQ_GET   = 3'd3,
    REQ_PRED  = 3'd4,
    REQ_SUCC  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // search token that walks the cell chain one cell per cycle
  typedef struct packed {
    logic              vld;
    logic              found;
    logic              pend;   // successor: match seen, take next cell
    logic [DATA_W-1:0] prev;   // entry of the cell just passed
    logic [DATA_W-1:0] result;
  } probe_t;

  typedef struct packed {
    logic shift_ins;
    logic shift_del;
    req_e op;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/ordered_list_store.sv]
`default_nettype none
`include "ordered_list_store_assert.svh"

// Positional list of up to CAPACITY signed 32-bit values, one request at a
// time. Entries sit in a chain of cells; insert and delete shift all cells
// together. Clear, insert, unused codes and position errors go from the
// evaluate state straight to the done state. Get, delete, predecessor and
// successor otherwise pass through a scan state first: a search token walks
// the cell chain one cell per cycle. The next request is taken in the cycle
// after the result beat is registered; a waiting result beat does not hold
// off that request, but a finished request holds until the output register is free.
module ordered_list_store #(
  parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic [5:0]         count_o,
  output logic               is_empty_o
);
  import olst_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  req_e              req_q;
  logic [5:0]        pos_q;
  logic [DATA_W-1:0] val_q;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_value_q, res_value_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_value_q;
  logic [5:0]        out_count_q;
  logic              out_empty_q;

  logic              accept, fire, need_scan;
  logic [PW-1:0]     pos_x, cnt_x, idx_x;
  logic [IW-1:0]     idx;
  cell_ctl_t         ctl;
  probe_t            launch;
  probe_t            chain [CAPACITY+1];
  logic [DATA_W-1:0] ent [CAPACITY];

  assign accept = in_valid_i && !in_stall_o;
  assign fire   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign pos_x  = PW'(pos_q);
  assign cnt_x  = PW'(cnt_q);
  assign idx_x  = pos_x - PW'(1);
  assign idx    = idx_x[IW-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    need_scan    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_status_d = ST_OK;
        res_value_d  = '0;
        case (req_q) inside
          REQ_INS: begin
            if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
              res_status_d = ST_RANGE;
            end else if (cnt_x == PW'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end
          end
          REQ_DEL, REQ_GET: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
              res_status_d = ST_RANGE;
            end else begin
              need_scan = 1'b1;
            end
          end
          REQ_PRED, REQ_SUCC: begin
            need_scan = 1'b1;
          end
          default: begin
          end
        endcase
        state_d = need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (chain[CAPACITY].vld) begin
          res_status_d = chain[CAPACITY].found ? ST_OK : ST_NOTFOUND;
          res_value_d  = chain[CAPACITY].found ? chain[CAPACITY].result : '0;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (fire) begin
          state_d = S_IDLE;
          if (res_status_q == ST_OK) begin
            case (req_q)
              REQ_CLEAR: cnt_d = '0;
              REQ_INS:   cnt_d = cnt_q + CW'(1);
              REQ_DEL:   cnt_d = cnt_q - CW'(1);
              default:   cnt_d = cnt_q;
            endcase
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    launch     = '0;
    launch.vld = (state_q == S_EVAL) && need_scan;
  end

  assign chain[0] = launch;

  assign ctl.shift_ins = fire && req_q == REQ_INS && res_status_q == ST_OK;
  assign ctl.shift_del = fire && req_q == REQ_DEL && res_status_q == ST_OK;
  assign ctl.op        = req_q;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = val_q;
    end else begin : g_mid
      assign left_w = ent[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = ent[k];
    end else begin : g_inner
      assign right_w = ent[k+1];
    end
    olst_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .idx_i   (idx),
      .cnt_i   (cnt_q),
      .key_i   (val_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[k]),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_type_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (fire) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= 6'(cnt_d);
      out_empty_q  <= (cnt_d == '0);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;
  assign count_o     = out_count_q;
  assign is_empty_o  = out_empty_q;

  `OLS_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_q <= CW'(CAPACITY), "fill count above capacity")
  `OLS_ASSERT_NEXT(a_out_src, state_q != S_DONE && !out_valid_o, !out_valid_o, "stray result beat")
  `OLS_ASSERT_NOW(a_probe_scan, chain[CAPACITY].vld, state_q == S_SCAN, "token out of a scan")
  `OLS_ASSERT_NEXT(a_ins_cnt, ctl.shift_ins, cnt_q == $past(cnt_q) + CW'(1), "insert count stuck")

endmodule

`default_nettype wire

[rtl/core/olst_cell.sv]
`default_nettype none

module olst_cell #(
  parameter int IW  = 5,
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  olst_pkg::cell_ctl_t       ctl_i,
  input  logic [IW-1:0]             idx_i,
  input  logic [CW-1:0]             cnt_i,
  input  logic [olst_pkg::DATA_W-1:0] key_i,
  input  logic [olst_pkg::DATA_W-1:0] left_i,
  input  logic [olst_pkg::DATA_W-1:0] right_i,
  output logic [olst_pkg::DATA_W-1:0] entry_o,
  input  olst_pkg::probe_t          probe_i,
  output olst_pkg::probe_t          probe_o
);
  import olst_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic [DATA_W-1:0] entry_q, entry_d;
  probe_t            probe_q, probe_d;
  logic              in_use;

  assign in_use = MY_CNT < cnt_i;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift_ins && idx_i == MY_IDX) begin
      entry_d = key_i;
    end else if (ctl_i.shift_ins && idx_i < MY_IDX) begin
      entry_d = left_i;
    end else if (ctl_i.shift_del && idx_i <= MY_IDX) begin
      entry_d = right_i;
    end
  end

  always_comb begin
    probe_d      = probe_i;
    probe_d.prev = entry_q;
    if (probe_i.vld && !probe_i.found && in_use) begin
      case (ctl_i.op) inside
        REQ_GET, REQ_DEL: begin
          if (idx_i == MY_IDX) begin
            probe_d.found  = 1'b1;
            probe_d.result = entry_q;
          end
        end
        REQ_PRED: begin
          if (MY_IDX != '0 && entry_q == key_i) begin
            probe_d.found  = 1'b1;
            probe_d.result = probe_i.prev;
          end
        end
        REQ_SUCC: begin
          if (probe_i.pend) begin
            probe_d.found  = 1'b1;
            probe_d.result = entry_q;
          end else if (entry_q == key_i) begin
            probe_d.pend = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;

endmodule

`default_nettype wire

[verif/ordered_list_store_tb.sv]
`timescale 1ns / 1ps

module ordered_list_store_tb;
  import olst_pkg::*;

  localparam logic [2:0] REQ_NOP6 = 3'd6;
  localparam logic [2:0] REQ_NOP7 = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_PER_PHASE = 584;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_e            status;
    logic signed [31:0] value;
    logic [5:0]         count;
    logic               is_empty;
  } reply_t;

  typedef struct {
    logic [2:0]         req;
    logic [5:0]         pos;
    logic signed [31:0] val;
    bit                 typed;
    reply_t             want;
  } stim_row_t;

  typedef enum {GROW, SHRINK, CHURN} drift_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         req_type_i;
  logic [5:0]         position_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] out_value_o;
  logic [5:0]         count_o;
  logic               is_empty_o;

  logic signed [31:0] shadow_list [CAPACITY_DEF];
  int                 shadow_len;
  reply_t             pending_replies [$];
  reply_t             oldest_reply;
  reply_t             no_reply;
  stim_row_t          directed_rows [24];
  logic signed [31:0] common_vals [8];
  int                 fault_count = 0;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  drift_e             drift;
  int                 drift_left;

  ordered_list_store uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic reply_t apply_request(input logic [2:0] req, input logic [5:0] pos,
                                           input logic signed [31:0] val);
    reply_t r;
    int     p;
    r.status = ST_OK;
    r.value = '0;
    p = int'(pos);
    case (req)
      REQ_CLEAR: shadow_len = 0;
      REQ_INS: begin
        if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          for (int k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = val;
          shadow_len++;
        end
      end
      REQ_DEL: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value = shadow_list[p-1];
          for (int k = p; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
        end
      end
      REQ_GET: begin
        if (p < 1 || p > shadow_len) r.status = ST_RANGE;
        else r.value = shadow_list[p-1];
      end
      REQ_PRED: begin
        r.status = ST_NOTFOUND;
        for (int k = 1; k < shadow_len; k++) begin
          if (shadow_list[k] == val) begin
            r.value = shadow_list[k-1];
            r.status = ST_OK;
            break;
          end
        end
      end
      REQ_SUCC: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k + 1 < shadow_len; k++) begin
          if (shadow_list[k] == val) begin
            r.value = shadow_list[k+1];
            r.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = 6'(shadow_len);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // called right after a rising edge; leaves valid high after the beat
  task automatic send_request(input logic [2:0] req, input logic [5:0] pos,
                              input logic signed [31:0] val, input bit has_typed,
                              input reply_t typed);
    reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_request(req, pos, val);
    if (has_typed) pending_replies.push_back(typed);
    else pending_replies.push_back(predicted);
  endtask

  task automatic pick_request(output logic [2:0] req, output logic [5:0] pos,
                              output logic signed [31:0] val);
    int roll;
    int ins_w;
    int del_w;
    if (drift_left == 0) begin
      drift = drift_e'($urandom_range(2));
      drift_left = $urandom_range(60, 20);
    end
    drift_left--;
    case (drift)
      GROW: begin
        ins_w = 70;
        del_w = 8;
      end
      SHRINK: begin
        ins_w = 12;
        del_w = 60;
      end
      default: begin
        ins_w = 35;
        del_w = 25;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w) begin
      req = REQ_INS;
    end else if (roll < ins_w + del_w) begin
      req = REQ_DEL;
    end else if (roll < 96) begin
      case ($urandom_range(2))
        0: req = REQ_GET;
        1: req = REQ_PRED;
        default: req = REQ_SUCC;
      endcase
    end else if (roll < 98) begin
      req = (drift == GROW) ? REQ_GET : REQ_CLEAR;
    end else begin
      req = (roll == 98) ? REQ_NOP6 : REQ_NOP7;
    end

    if ($urandom_range(99) < 85) begin
      if (req == REQ_INS) pos = 6'($urandom_range(shadow_len + 1, 1));
      else if (shadow_len > 0) pos = 6'($urandom_range(shadow_len, 1));
      else pos = 6'($urandom_range(63));
    end else begin
      pos = 6'($urandom_range(63));
    end

    roll = $urandom_range(99);
    if ((req == REQ_PRED || req == REQ_SUCC) && shadow_len > 0 && roll < 70)
      val = shadow_list[$urandom_range(shadow_len - 1)];
    else if (roll < 50)
      val = common_vals[$urandom_range(7)];
    else
      val = $signed($urandom());
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        flag_fault($sformatf("unexpected beat status=%0d value=%0d count=%0d empty=%0d",
                             status_o, out_value_o, count_o, is_empty_o));
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (status_o !== oldest_reply.status || out_value_o !== oldest_reply.value ||
            count_o !== oldest_reply.count || is_empty_o !== oldest_reply.is_empty)
          flag_fault($sformatf(
            "exp status=%0d value=%0d count=%0d empty=%0d, got %0d %0d %0d %0d",
            oldest_reply.status, oldest_reply.value, oldest_reply.count,
            oldest_reply.is_empty, status_o, out_value_o, count_o, is_empty_o));
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [2:0]         req;
    logic [5:0]         pos;
    logic signed [31:0] val;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_CLEAR;
    position_i     = '0;
    value_i        = '0;
    shadow_len     = 0;
    drift          = CHURN;
    drift_left     = 0;
    send_idle_pct  = 17;
    recv_stall_pct = 63;
    no_reply       = '{ST_OK, 32'sd0, 6'd0, 1'b0};
    common_vals    = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, -32'sd100, VAL_MIN, VAL_MAX};

    // list after row 11: -1, 7, MIN, MAX, 7
    directed_rows = '{
      '{REQ_GET,   6'd1,  32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 6'd0, 1'b1}},
      '{REQ_DEL,   6'd0,  32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 6'd0, 1'b1}},
      '{REQ_SUCC,  6'd0,  32'sd0,  1'b1, '{ST_NOTFOUND, 32'sd0, 6'd0, 1'b1}},
      '{REQ_PRED,  6'd0,  32'sd0,  1'b1, '{ST_NOTFOUND, 32'sd0, 6'd0, 1'b1}},
      '{REQ_INS,   6'd2,  32'sd5,  1'b1, '{ST_RANGE,    32'sd0, 6'd0, 1'b1}},
      '{REQ_INS,   6'd0,  32'sd5,  1'b1, '{ST_RANGE,    32'sd0, 6'd0, 1'b1}},
      '{REQ_INS,   6'd1,  VAL_MIN, 1'b1, '{ST_OK,       32'sd0, 6'd1, 1'b0}},
      '{REQ_INS,   6'd2,  VAL_MAX, 1'b1, '{ST_OK,       32'sd0, 6'd2, 1'b0}},
      '{REQ_INS,   6'd1,  -32'sd1, 1'b1, '{ST_OK,       32'sd0, 6'd3, 1'b0}},
      '{REQ_INS,   6'd2,  32'sd7,  1'b0, no_reply},
      '{REQ_INS,   6'd5,  32'sd7,  1'b0, no_reply},
      '{REQ_GET,   6'd3,  32'sd0,  1'b0, no_reply},
      '{REQ_PRED,  6'd0,  32'sd7,  1'b0, no_reply},
      '{REQ_SUCC,  6'd0,  32'sd7,  1'b0, no_reply},
      '{REQ_PRED,  6'd0,  -32'sd1, 1'b1, '{ST_NOTFOUND, 32'sd0, 6'd5, 1'b0}},
      '{REQ_SUCC,  6'd0,  VAL_MAX, 1'b0, no_reply},
      '{REQ_GET,   6'd63, 32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 6'd5, 1'b0}},
      '{REQ_INS,   6'd63, 32'sd3,  1'b1, '{ST_RANGE,    32'sd0, 6'd5, 1'b0}},
      '{REQ_NOP6,  6'd1,  32'sd9,  1'b1, '{ST_OK,       32'sd0, 6'd5, 1'b0}},
      '{REQ_NOP7,  6'd1,  32'sd9,  1'b1, '{ST_OK,       32'sd0, 6'd5, 1'b0}},
      '{REQ_DEL,   6'd5,  32'sd0,  1'b0, no_reply},
      '{REQ_DEL,   6'd1,  32'sd0,  1'b0, no_reply},
      '{REQ_CLEAR, 6'd0,  32'sd0,  1'b1, '{ST_OK,       32'sd0, 6'd0, 1'b1}},
      '{REQ_GET,   6'd1,  32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 6'd0, 1'b1}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        pick_request(req, pos, val);
        send_request(req, pos, val, 1'b0, no_reply);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fault_count == 0 && pending_replies.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/olst_pkg.sv
rtl/core/olst_cell.sv
rtl/core/ordered_list_store.sv
verif/ordered_list_store_tb.sv
